[src/btha_pkg.sv]
// ----------------------------------------------------------------------------
// btha_pkg
// Shared constants, codes and types of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package btha_pkg;

    // Field widths
    localparam int REQ_W  = 17;   // requested payload bytes
    localparam int FW_W   = 14;   // payload word index to free
    localparam int PW_W   = 14;   // returned payload word index
    localparam int ST_W   = 2;    // status code
    localparam int GROW_W = 15;   // grow size register
    localparam int ASZ_W  = 15;   // rounded block size of a request

    // Heap geometry
    localparam int HEAP_WORDS_DEF = 16384;
    localparam int WORD_BYTES     = 8;
    localparam int CHUNK_BYTES    = 1024 * 5;
    localparam int GROW_RESET     = CHUNK_BYTES / WORD_BYTES;
    localparam int MIN_BLK        = 4;            // smallest block, words
    localparam int SMALL_REQ      = 8;            // bytes that still fit a minimum block
    localparam int REQ_ROUND      = 23;           // 16 bytes of tags plus 7 for rounding up
    localparam int PROLOGUE_TAG   = (2 << 1) | 1; // size 2, allocated
    localparam int EPILOGUE_TAG   = 1;            // size 0, allocated

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OOM  = 2'd2
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [REQ_W-1:0]  req_bytes;
        logic [FW_W-1:0]   free_word;
    } eng_req_t;

    typedef struct packed {
        logic [PW_W-1:0]   payload_word;
        status_t           status;
    } eng_rsp_t;

    // Where a free-list unlink returns to
    typedef enum logic [1:0] {
        RET_MERGE_N,
        RET_MERGE_P,
        RET_PLACE
    } lr_ret_t;

    typedef enum logic [5:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_W_CHK,
        S_W_SZ,
        S_W_NX,
        S_NOFIT,
        S_G_W1,
        S_G_W2,
        S_M_PF_RD,
        S_M_PF,
        S_M_PH,
        S_M_NH,
        S_M_AFTN,
        S_M_MK1,
        S_M_MK2,
        S_M_P1,
        S_M_P2,
        S_M_P3,
        S_LR_A,
        S_LR_B,
        S_LR_C,
        S_LR_D,
        S_PL_START,
        S_PL_P,
        S_PL_N,
        S_PL_S2,
        S_PL_S3,
        S_PL_S4,
        S_PL_S5,
        S_PL_S6,
        S_PL_S7,
        S_PL_S8,
        S_PL_FULL,
        S_PL_FULL2,
        S_F_H,
        S_F_F,
        S_F_W2,
        S_DONE
    } eng_state_t;

endpackage

`default_nettype wire

[src/btha_ram.sv]
// ----------------------------------------------------------------------------
// btha_ram
// Heap word store: one port, registered read, range check on the address.
// ----------------------------------------------------------------------------
`default_nettype none

module btha_ram #(
    parameter int HEAP_WORDS = btha_pkg::HEAP_WORDS_DEF
) (
    clk,
    we,
    addr,
    wdata,
    rdata
);
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int DW = AW + 2;
    localparam int XW = (DW > 16) ? DW : 16;

    input  wire logic          clk;
    input  wire logic          we;
    input  wire logic [XW-1:0] addr;
    input  wire logic [DW-1:0] wdata;
    output      logic [XW-1:0] rdata;

    logic [DW-1:0] mem [HEAP_WORDS];
    logic [DW-1:0] rd_q;
    logic          oob_q;
    logic          in_rng;

    assign in_rng = (addr < XW'(HEAP_WORDS));

    // Writes outside the heap are dropped
    always_ff @(posedge clk)
    begin
        if (we && in_rng)
        begin
            mem[addr[AW-1:0]] <= wdata;
        end
        rd_q  <= mem[addr[AW-1:0]];
        oob_q <= !in_rng;
    end

    // Reads outside the heap give zero
    assign rdata = oob_q ? '0 : XW'(rd_q);

endmodule

`default_nettype wire

[src/btha_engine.sv]
// ----------------------------------------------------------------------------
// btha_engine
// Sequencer that walks, splits, grows and merges heap blocks in the store.
// ----------------------------------------------------------------------------
`default_nettype none

module btha_engine #(
    parameter int HEAP_WORDS = btha_pkg::HEAP_WORDS_DEF
) (
    clk,
    rst_n,
    grow_words,
    req_valid,
    req,
    req_ready,
    rsp_valid,
    rsp,
    rsp_ready
);
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int DW = AW + 2;
    localparam int XW = (DW > 16) ? DW : 16;
    localparam int CHUNK_OK  = (4 + btha_pkg::GROW_RESET <= HEAP_WORDS) ? 1 : 0;
    localparam int HEAD_RST  = (CHUNK_OK != 0) ? 3 : 0;
    localparam int BRK_RST   = (CHUNK_OK != 0) ? 4 + btha_pkg::GROW_RESET : 4;
    localparam int CHUNK_FTR = 3 + btha_pkg::GROW_RESET - 1;
    localparam int CHUNK_EPI = 3 + btha_pkg::GROW_RESET;

    input  wire logic                        clk;
    input  wire logic                        rst_n;
    input  wire logic [btha_pkg::GROW_W-1:0] grow_words;
    input  wire logic                        req_valid;
    input  wire btha_pkg::eng_req_t          req;
    output      logic                        req_ready;
    output      logic                        rsp_valid;
    output      btha_pkg::eng_rsp_t          rsp;
    input  wire logic                        rsp_ready;

    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_WORDS);
    localparam logic [XW-1:0] MIN_X  = XW'(btha_pkg::MIN_BLK);
    localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_WORDS - 1);

    btha_pkg::eng_state_t state_reg, state_next;
    btha_pkg::lr_ret_t    ret_reg, ret_next;
    btha_pkg::action_t    act_reg, act_next;
    btha_pkg::status_t    status_reg, status_next;

    logic [btha_pkg::ASZ_W-1:0] a_reg, a_next;
    logic                       zero_reg, zero_next;
    logic [XW-1:0] cur_reg, cur_next;
    logic [XW-1:0] sz_reg, sz_next;
    logic [XW-1:0] x_reg, x_next;
    logic [XW-1:0] p_reg, p_next;
    logic [XW-1:0] n_reg, n_next;
    logic [XW-1:0] pv_reg, pv_next;
    logic [XW-1:0] psz_reg, psz_next;
    logic [XW-1:0] h_reg, h_next;
    logic          pfree_reg, pfree_next;
    logic [AW:0]   steps_reg, steps_next;
    logic [XW-1:0] head_reg, head_next;
    logic [XW-1:0] brk_reg, brk_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [btha_pkg::PW_W-1:0] pay_reg, pay_next;

    // Store port
    logic          mem_we;
    logic [XW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata;
    logic [XW-1:0] rd;

    btha_ram #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd)
    );

    // Shared terms
    logic [XW-1:0] rd_sz, ax, gx, ext, pv_addr, rem;
    logic [btha_pkg::REQ_W:0] rq_sum;
    logic walk_end, fit, oom, split, free_ok;

    assign rd_sz    = rd >> 1;
    assign ax       = XW'(a_reg);
    assign gx       = XW'(grow_words);
    assign ext      = (ax > gx) ? ax : gx;
    assign oom      = (brk_reg + ext) > HEAP_X;
    assign walk_end = (cur_reg == '0) || (steps_reg >= (AW+1)'(HEAP_WORDS));
    assign fit      = (rd_sz < MIN_X) || ((rd_sz - MIN_X) > ax);
    assign split    = (ax + MIN_X) < sz_reg;
    assign rem      = sz_reg - ax;
    assign pv_addr  = cur_reg - rd_sz;
    assign free_ok  = (cur_reg >= XW'(3)) && rd[0] && (rd_sz >= MIN_X)
                      && ((cur_reg + rd_sz) <= (brk_reg - XW'(1)));
    assign rq_sum   = {1'b0, req.req_bytes} + (btha_pkg::REQ_W+1)'(btha_pkg::REQ_ROUND);

    // Contents after reset: prologue, initial free chunk (when it fits the heap), epilogue
    function automatic logic [DW-1:0] init_word(input logic [AW-1:0] adr);
        logic [XW-1:0] ax_w;
        logic [DW-1:0] v;
        ax_w = XW'(adr);
        v    = '0;
        if (ax_w == XW'(1) || ax_w == XW'(2))
        begin
            v = DW'(btha_pkg::PROLOGUE_TAG);
        end
        else if (ax_w == XW'(3))
        begin
            v = (CHUNK_OK != 0) ? DW'(btha_pkg::GROW_RESET << 1)
                                : DW'(btha_pkg::EPILOGUE_TAG);
        end
        else if ((CHUNK_OK != 0) && ax_w == XW'(CHUNK_FTR))
        begin
            v = DW'(btha_pkg::GROW_RESET << 1);
        end
        else if ((CHUNK_OK != 0) && ax_w == XW'(CHUNK_EPI))
        begin
            v = DW'(btha_pkg::EPILOGUE_TAG);
        end
        return v;
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btha_pkg::S_CLEAR:    if (clr_reg == CLR_LAST) state_next = btha_pkg::S_IDLE;
            btha_pkg::S_IDLE:     if (req_valid) state_next = btha_pkg::S_DECODE;
            btha_pkg::S_DECODE:
            begin
                if (zero_reg)
                    state_next = btha_pkg::S_DONE;
                else if (act_reg == btha_pkg::ACT_FREE)
                    state_next = btha_pkg::S_F_H;
                else
                    state_next = btha_pkg::S_W_CHK;
            end
            btha_pkg::S_W_CHK:    state_next = walk_end ? btha_pkg::S_NOFIT : btha_pkg::S_W_SZ;
            btha_pkg::S_W_SZ:     state_next = fit ? btha_pkg::S_PL_START : btha_pkg::S_W_NX;
            btha_pkg::S_W_NX:     state_next = btha_pkg::S_W_CHK;
            btha_pkg::S_NOFIT:    state_next = oom ? btha_pkg::S_DONE : btha_pkg::S_G_W1;
            btha_pkg::S_G_W1:     state_next = btha_pkg::S_G_W2;
            btha_pkg::S_G_W2:     state_next = btha_pkg::S_M_PF_RD;
            btha_pkg::S_M_PF_RD:  state_next = btha_pkg::S_M_PF;
            btha_pkg::S_M_PF:     state_next = btha_pkg::S_M_PH;
            btha_pkg::S_M_PH:     state_next = btha_pkg::S_M_NH;
            btha_pkg::S_M_NH:     state_next = rd[0] ? btha_pkg::S_M_AFTN : btha_pkg::S_LR_A;
            btha_pkg::S_M_AFTN:   state_next = pfree_reg ? btha_pkg::S_LR_A : btha_pkg::S_M_MK1;
            btha_pkg::S_M_MK1:    state_next = btha_pkg::S_M_MK2;
            btha_pkg::S_M_MK2:    state_next = btha_pkg::S_M_P1;
            btha_pkg::S_M_P1:     state_next = btha_pkg::S_M_P2;
            btha_pkg::S_M_P2:     state_next = btha_pkg::S_M_P3;
            btha_pkg::S_M_P3:
            begin
                state_next = (act_reg == btha_pkg::ACT_ALLOC) ? btha_pkg::S_PL_START
                                                              : btha_pkg::S_DONE;
            end
            btha_pkg::S_LR_A:     state_next = btha_pkg::S_LR_B;
            btha_pkg::S_LR_B:     state_next = btha_pkg::S_LR_C;
            btha_pkg::S_LR_C:     state_next = btha_pkg::S_LR_D;
            btha_pkg::S_LR_D:
            begin
                unique case (ret_reg)
                    btha_pkg::RET_MERGE_N: state_next = btha_pkg::S_M_AFTN;
                    btha_pkg::RET_MERGE_P: state_next = btha_pkg::S_M_MK1;
                    btha_pkg::RET_PLACE:   state_next = btha_pkg::S_PL_FULL;
                    default:               state_next = btha_pkg::S_PL_FULL;
                endcase
            end
            btha_pkg::S_PL_START: state_next = split ? btha_pkg::S_PL_P : btha_pkg::S_LR_A;
            btha_pkg::S_PL_P:     state_next = btha_pkg::S_PL_N;
            btha_pkg::S_PL_N:     state_next = btha_pkg::S_PL_S2;
            btha_pkg::S_PL_S2:    state_next = btha_pkg::S_PL_S3;
            btha_pkg::S_PL_S3:    state_next = btha_pkg::S_PL_S4;
            btha_pkg::S_PL_S4:    state_next = btha_pkg::S_PL_S5;
            btha_pkg::S_PL_S5:    state_next = btha_pkg::S_PL_S6;
            btha_pkg::S_PL_S6:    state_next = btha_pkg::S_PL_S7;
            btha_pkg::S_PL_S7:    state_next = btha_pkg::S_PL_S8;
            btha_pkg::S_PL_S8:    state_next = btha_pkg::S_DONE;
            btha_pkg::S_PL_FULL:  state_next = btha_pkg::S_PL_FULL2;
            btha_pkg::S_PL_FULL2: state_next = btha_pkg::S_DONE;
            btha_pkg::S_F_H:      state_next = free_ok ? btha_pkg::S_F_F : btha_pkg::S_DONE;
            btha_pkg::S_F_F:      state_next = (rd == h_reg) ? btha_pkg::S_F_W2 : btha_pkg::S_DONE;
            btha_pkg::S_F_W2:     state_next = btha_pkg::S_M_PF_RD;
            btha_pkg::S_DONE:     if (rsp_ready) state_next = btha_pkg::S_IDLE;
            default:              state_next = btha_pkg::S_IDLE;
        endcase
    end

    // Store port and handshake outputs
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            btha_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = XW'(clr_reg);
                mem_wdata = init_word(clr_reg);
            end
            btha_pkg::S_DECODE, btha_pkg::S_W_CHK: mem_addr = cur_reg;
            btha_pkg::S_W_SZ:    mem_addr = cur_reg + XW'(2);
            btha_pkg::S_NOFIT:
            begin
                mem_we    = !oom;
                mem_addr  = brk_reg - XW'(1);
                mem_wdata = DW'(ext << 1);
            end
            btha_pkg::S_G_W1:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + sz_reg - XW'(1);
                mem_wdata = DW'(sz_reg << 1);
            end
            btha_pkg::S_G_W2:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + sz_reg;
                mem_wdata = DW'(btha_pkg::EPILOGUE_TAG);
            end
            btha_pkg::S_M_PF_RD: mem_addr = cur_reg - XW'(1);
            btha_pkg::S_M_PF:    mem_addr = pv_addr;
            btha_pkg::S_M_PH:    mem_addr = cur_reg + sz_reg;
            btha_pkg::S_M_MK1:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = DW'(sz_reg << 1);
            end
            btha_pkg::S_M_MK2:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + sz_reg - XW'(1);
                mem_wdata = DW'(sz_reg << 1);
            end
            btha_pkg::S_M_P1:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + XW'(2);
                mem_wdata = DW'(head_reg);
            end
            btha_pkg::S_M_P2:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + XW'(1);
            end
            btha_pkg::S_M_P3:
            begin
                mem_we    = (head_reg != '0);
                mem_addr  = head_reg + XW'(1);
                mem_wdata = DW'(cur_reg);
            end
            btha_pkg::S_LR_A:    mem_addr = x_reg + XW'(1);
            btha_pkg::S_LR_B:    mem_addr = x_reg + XW'(2);
            btha_pkg::S_LR_C:
            begin
                mem_we    = (rd != '0);
                mem_addr  = rd + XW'(1);
                mem_wdata = DW'(p_reg);
            end
            btha_pkg::S_LR_D:
            begin
                mem_we    = (p_reg != '0);
                mem_addr  = p_reg + XW'(2);
                mem_wdata = DW'(n_reg);
            end
            btha_pkg::S_PL_START: mem_addr = cur_reg + XW'(1);
            btha_pkg::S_PL_P:     mem_addr = cur_reg + XW'(2);
            btha_pkg::S_PL_N:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + ax;
                mem_wdata = DW'(rem << 1);
            end
            btha_pkg::S_PL_S2:
            begin
                mem_we    = 1'b1;
                mem_addr  = x_reg + rem - XW'(1);
                mem_wdata = DW'(rem << 1);
            end
            btha_pkg::S_PL_S3:
            begin
                mem_we    = 1'b1;
                mem_addr  = x_reg + XW'(1);
                mem_wdata = DW'(p_reg);
            end
            btha_pkg::S_PL_S4:
            begin
                mem_we    = 1'b1;
                mem_addr  = x_reg + XW'(2);
                mem_wdata = DW'(n_reg);
            end
            btha_pkg::S_PL_S5:
            begin
                mem_we    = (n_reg != '0);
                mem_addr  = n_reg + XW'(1);
                mem_wdata = DW'(x_reg);
            end
            btha_pkg::S_PL_S6:
            begin
                mem_we    = (p_reg != '0);
                mem_addr  = p_reg + XW'(2);
                mem_wdata = DW'(x_reg);
            end
            btha_pkg::S_PL_S7:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = DW'((ax << 1) | XW'(1));
            end
            btha_pkg::S_PL_S8:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + ax - XW'(1);
                mem_wdata = DW'((ax << 1) | XW'(1));
            end
            btha_pkg::S_PL_FULL:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = DW'((sz_reg << 1) | XW'(1));
            end
            btha_pkg::S_PL_FULL2:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + sz_reg - XW'(1);
                mem_wdata = DW'((sz_reg << 1) | XW'(1));
            end
            btha_pkg::S_F_H:     mem_addr = cur_reg + rd_sz - XW'(1);
            btha_pkg::S_F_F:
            begin
                mem_we    = (rd == h_reg);
                mem_addr  = cur_reg;
                mem_wdata = DW'(sz_reg << 1);
            end
            btha_pkg::S_F_W2:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg + sz_reg - XW'(1);
                mem_wdata = DW'(sz_reg << 1);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign req_ready = (state_reg == btha_pkg::S_IDLE);
    assign rsp_valid = (state_reg == btha_pkg::S_DONE);
    assign rsp.payload_word = pay_reg;
    assign rsp.status       = status_reg;

    // Datapath registers
    always_comb
    begin
        ret_next    = ret_reg;
        act_next    = act_reg;
        status_next = status_reg;
        a_next      = a_reg;
        zero_next   = zero_reg;
        cur_next    = cur_reg;
        sz_next     = sz_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        pv_next     = pv_reg;
        psz_next    = psz_reg;
        h_next      = h_reg;
        pfree_next  = pfree_reg;
        steps_next  = steps_reg;
        head_next   = head_reg;
        brk_next    = brk_reg;
        clr_next    = clr_reg;
        pay_next    = pay_reg;
        case (state_reg)
            btha_pkg::S_CLEAR: clr_next = clr_reg + AW'(1);
            btha_pkg::S_IDLE:
            begin
                act_next    = req.action;
                status_next = btha_pkg::ST_OK;
                pay_next    = '0;
                steps_next  = '0;
                cur_next    = XW'(req.free_word) - XW'(1);
                if (req.req_bytes <= btha_pkg::REQ_W'(btha_pkg::SMALL_REQ))
                    a_next = btha_pkg::ASZ_W'(btha_pkg::MIN_BLK);
                else
                    a_next = rq_sum[btha_pkg::REQ_W:3];
                if (req.action == btha_pkg::ACT_FREE)
                    zero_next = (req.free_word == '0);
                else
                    zero_next = (req.req_bytes == '0);
            end
            btha_pkg::S_DECODE:
            begin
                if (act_reg == btha_pkg::ACT_ALLOC)
                begin
                    cur_next = head_reg;
                    if (zero_reg)
                        status_next = btha_pkg::ST_ZERO;
                end
            end
            btha_pkg::S_W_SZ: if (fit) sz_next = rd_sz;
            btha_pkg::S_W_NX:
            begin
                cur_next   = rd;
                steps_next = steps_reg + (AW+1)'(1);
            end
            btha_pkg::S_NOFIT:
            begin
                if (oom)
                begin
                    status_next = btha_pkg::ST_OOM;
                end
                else
                begin
                    cur_next = brk_reg - XW'(1);
                    sz_next  = ext;
                end
            end
            btha_pkg::S_G_W2: brk_next = brk_reg + sz_reg;
            btha_pkg::S_M_PF: pv_next  = pv_addr;
            btha_pkg::S_M_PH:
            begin
                pfree_next = !rd[0];
                psz_next   = rd_sz;
            end
            btha_pkg::S_M_NH:
            begin
                x_next   = cur_reg + sz_reg;
                ret_next = btha_pkg::RET_MERGE_N;
                if (!rd[0])
                    sz_next = sz_reg + rd_sz;
            end
            btha_pkg::S_M_AFTN:
            begin
                if (pfree_reg)
                begin
                    x_next   = pv_reg;
                    cur_next = pv_reg;
                    sz_next  = sz_reg + psz_reg;
                    ret_next = btha_pkg::RET_MERGE_P;
                end
            end
            btha_pkg::S_M_P3: head_next = cur_reg;
            btha_pkg::S_LR_B: p_next = rd;
            btha_pkg::S_LR_C: n_next = rd;
            btha_pkg::S_LR_D: if (p_reg == '0) head_next = n_reg;
            btha_pkg::S_PL_START:
            begin
                if (!split)
                begin
                    x_next   = cur_reg;
                    ret_next = btha_pkg::RET_PLACE;
                end
            end
            btha_pkg::S_PL_P: p_next = rd;
            btha_pkg::S_PL_N:
            begin
                n_next = rd;
                x_next = cur_reg + ax;
            end
            btha_pkg::S_PL_S6: if (head_reg == cur_reg) head_next = x_reg;
            btha_pkg::S_PL_S8, btha_pkg::S_PL_FULL2:
            begin
                pay_next = btha_pkg::PW_W'(cur_reg + XW'(1));
            end
            btha_pkg::S_F_H:
            begin
                h_next  = rd;
                sz_next = rd_sz;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btha_pkg::S_CLEAR;
            clr_reg   <= '0;
            head_reg  <= XW'(HEAD_RST);
            brk_reg   <= XW'(BRK_RST);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            brk_reg   <= brk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        act_reg    <= act_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        zero_reg   <= zero_next;
        cur_reg    <= cur_next;
        sz_reg     <= sz_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        pv_reg     <= pv_next;
        psz_reg    <= psz_next;
        h_reg      <= h_next;
        pfree_reg  <= pfree_next;
        steps_reg  <= steps_next;
        pay_reg    <= pay_next;
    end

endmodule

`default_nettype wire

[src/boundary_tag_heap_allocator_core.sv]
// Request kinds: a zero-size allocate or a null free is answered with no store write;
// a free that fails its tag checks is rejected; a free merges with free neighbors.
// An allocate walks the free list first-fit, grows the heap when no block fits or
// answers out of memory, and places the block whole or splits it.
// Throughput: one beat at a time; s_tready rises once the result enters the output register.
// Reset: asynchronous; then a clearing pass loads every store word while s_tready is low.
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// Explicit free-list first-fit heap allocator: stream ports, grow register.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_core #(
    parameter int HEAP_WORDS = btha_pkg::HEAP_WORDS_DEF
) (
    clk,
    rst_n,
    cfg_wr_en,
    cfg_wr_data,
    s_tvalid,
    s_tready,
    s_tdata,
    s_tuser,
    m_tvalid,
    m_tready,
    m_tdata
);
    input  wire logic                        clk;
    input  wire logic                        rst_n;
    input  wire logic                        cfg_wr_en;
    input  wire logic [btha_pkg::GROW_W-1:0] cfg_wr_data;  // grow_words
    input  wire logic                        s_tvalid;
    output      logic                        s_tready;
    input  wire logic [31:0]                 s_tdata;      // req_bytes[16:0], free_word[30:17]
    input  wire logic                        s_tuser;      // action
    output      logic                        m_tvalid;
    input  wire logic                        m_tready;
    output      logic [15:0]                 m_tdata;      // payload_word[13:0], status[15:14]

    logic [btha_pkg::GROW_W-1:0] grow_reg;
    btha_pkg::eng_req_t eng_req;
    btha_pkg::eng_rsp_t eng_rsp, out_reg;
    logic eng_rsp_valid, eng_rsp_ready, out_valid_reg;

    // Grow size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grow_reg <= btha_pkg::GROW_W'(btha_pkg::GROW_RESET);
        else if (cfg_wr_en)
            grow_reg <= cfg_wr_data;
    end

    // Input beat unpacking
    assign eng_req.action    = btha_pkg::action_t'(s_tuser);
    assign eng_req.req_bytes = s_tdata[btha_pkg::REQ_W-1:0];
    assign eng_req.free_word = s_tdata[btha_pkg::REQ_W +: btha_pkg::FW_W];

    btha_engine #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .grow_words (grow_reg),
        .req_valid  (s_tvalid),
        .req        (eng_req),
        .req_ready  (s_tready),
        .rsp_valid  (eng_rsp_valid),
        .rsp        (eng_rsp),
        .rsp_ready  (eng_rsp_ready)
    );

    // Output register
    assign eng_rsp_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eng_rsp_ready)
            out_valid_reg <= eng_rsp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (eng_rsp_ready && eng_rsp_valid)
            out_reg <= eng_rsp;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.status, out_reg.payload_word};

endmodule

`default_nettype wire

[src/btha_checker.sv]
// ----------------------------------------------------------------------------
// btha_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module btha_checker (
    clk,
    rst_n,
    s_tvalid,
    s_tready,
    m_tvalid,
    m_tready,
    m_tdata
);
    input wire logic        clk;
    input wire logic        rst_n;
    input wire logic        s_tvalid;
    input wire logic        s_tready;
    input wire logic        m_tvalid;
    input wire logic        m_tready;
    input wire logic [15:0] m_tdata;

    // Held result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Only one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    // No undefined status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:14] != 2'd3)
        else $error("bad status code");

    // Failed allocations return null
    a_null_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:14] != 2'd0 |-> m_tdata[13:0] == 14'd0)
        else $error("non-null payload with error status");

endmodule

bind boundary_tag_heap_allocator_core btha_checker u_btha_checker (.*);

`default_nettype wire
